@@ hdl/kcfr_pkg.sv @@
// Shared types, register codes and slot helpers for the keyframe clip frame resolver.
package kcfr_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_BITS   = 16;
  localparam int ID_BITS     = 8;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [63:0] DUR_RESET = 64'h0001_0001_0001_0001;
  localparam logic [3:0]  FRAME_COUNT_RESET = 4'd1;

  typedef enum logic [2:0] {
    REG_ONCE_MODE,
    REG_FRAME_COUNT,
    REG_DUR_LOW,
    REG_DUR_HIGH,
    REG_FRAME_IDS
  } reg_idx_t;

  typedef struct packed {
    logic        once_mode;
    logic [3:0]  frame_count;
    logic [63:0] durations_low;
    logic [63:0] durations_high;
    logic [63:0] frame_ids;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  function automatic logic [SLOT_BITS-1:0] dur_slot(cfg_t c, logic [2:0] k);
    logic [2*64-1:0] w;
    w = {c.durations_high, c.durations_low};
    return w[k*SLOT_BITS +: SLOT_BITS];
  endfunction

  function automatic logic [ID_BITS-1:0] id_slot(cfg_t c, logic [2:0] k);
    return c.frame_ids[k*ID_BITS +: ID_BITS];
  endfunction

endpackage

@@ hdl/kcfr_cfg.sv @@
// APB register file holding clip mode, frame count, durations and frame ids.
module kcfr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kcfr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kcfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kcfr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output kcfr_pkg::cfg_t                  cfg
);
  import kcfr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.once_mode      <= 1'b0;
      cfg.frame_count    <= FRAME_COUNT_RESET;
      cfg.durations_low  <= DUR_RESET;
      cfg.durations_high <= DUR_RESET;
      cfg.frame_ids      <= '0;
    end else if (wr) begin
      case (idx)
        REG_ONCE_MODE:   cfg.once_mode      <= pwdata[0];
        REG_FRAME_COUNT: cfg.frame_count    <= pwdata[3:0];
        REG_DUR_LOW:     cfg.durations_low  <= pwdata;
        REG_DUR_HIGH:    cfg.durations_high <= pwdata;
        REG_FRAME_IDS:   cfg.frame_ids      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ONCE_MODE:   prdata = {{(APB_DATA_W-1){1'b0}}, cfg.once_mode};
      REG_FRAME_COUNT: prdata = {{(APB_DATA_W-4){1'b0}}, cfg.frame_count};
      REG_DUR_LOW:     prdata = cfg.durations_low;
      REG_DUR_HIGH:    prdata = cfg.durations_high;
      REG_FRAME_IDS:   prdata = cfg.frame_ids;
      default:         prdata = '0;
    endcase
  end

endmodule

@@ hdl/kcfr_alu.sv @@
// Shared adder/subtractor with borrow out, used by every step of the sequencer.
module kcfr_alu #(
  parameter int W = 34
) (
  input  kcfr_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      y,
  output logic              borrow
);
  import kcfr_pkg::*;

  logic [W:0] full;

  always_comb begin
    case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
    y      = full[W-1:0];
    borrow = (op == ALU_SUB) && full[W];
  end

endmodule

@@ hdl/kcfr_seq.sv @@
// Sequencer: clip total, once-mode end check, restoring modulo, frame walk, output register.
module kcfr_seq #(
  parameter int MAX_FRAMES    = 8,
  parameter int DURATION_BITS = 16,
  parameter int TW            = 32,
  parameter int SW            = 20,
  parameter int AW            = 33
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kcfr_pkg::cfg_t                   cfg,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kcfr_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kcfr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tuser,
  output kcfr_pkg::alu_op_t                alu_op,
  output logic [AW-1:0]                    alu_a,
  output logic [AW-1:0]                    alu_b,
  input  logic [AW-1:0]                    alu_y,
  input  logic                             alu_borrow
);
  import kcfr_pkg::*;

  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int BW = $clog2(TW);

  state_t state, state_next;

  logic [TW-1:0]            t;
  logic [SW-1:0]            acc;
  logic [SW-1:0]            rem;
  logic [NW-1:0]            cnt;
  logic [BW-1:0]            bcnt;
  logic                     fin;
  logic                     out_valid;

  logic [NW-1:0]            n;
  logic [NW-1:0]            n_last;
  logic [NW:0]              cnt_inc;
  logic [2:0]               k3;
  logic [SLOT_BITS-1:0]     slot;
  logic [DURATION_BITS-1:0] dur;
  logic                     load;

  always_comb begin
    if (cfg.frame_count == 4'd0) begin
      n = NW'(1);
    end else if (cfg.frame_count > 4'(MAX_FRAMES)) begin
      n = NW'(MAX_FRAMES);
    end else begin
      n = NW'(cfg.frame_count);
    end
    n_last  = n - NW'(1);
    cnt_inc = {1'b0, cnt} + (NW+1)'(1);
    k3      = 3'(cnt);
    slot    = dur_slot(cfg, k3);
    dur     = (slot[DURATION_BITS-1:0] == '0) ? DURATION_BITS'(1)
                                              : slot[DURATION_BITS-1:0];
  end

  assign s_tready = (state == ST_IDLE) && !rst;
  assign m_tvalid = out_valid;
  assign load     = (state == ST_DONE) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SUM;
      end
      ST_SUM: begin
        alu_op = ALU_ADD;
        alu_a  = AW'(acc);
        alu_b  = AW'(dur);
        if (cnt == n_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(t);
        alu_b  = AW'(acc);
        if (cfg.once_mode && !alu_borrow) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = AW'({rem, t[bcnt]});
        alu_b  = AW'(acc);
        if (bcnt == '0) state_next = ST_WALK;
      end
      ST_WALK: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(rem);
        alu_b  = AW'(dur);
        if (alu_borrow || cnt_inc >= {1'b0, n}) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          t   <= s_tdata[TW-1:0];
          acc <= '0;
          cnt <= '0;
          fin <= 1'b0;
        end
      end
      ST_SUM: begin
        acc <= alu_y[SW-1:0];
        if (cnt != n_last) cnt <= cnt_inc[NW-1:0];
      end
      ST_CHECK: begin
        rem  <= '0;
        bcnt <= BW'(TW - 1);
        if (cfg.once_mode && !alu_borrow) begin
          fin <= 1'b1;
          cnt <= n_last;
        end else begin
          cnt <= '0;
        end
      end
      ST_DIV: begin
        if (alu_borrow) begin
          rem <= alu_a[SW-1:0];
        end else begin
          rem <= alu_y[SW-1:0];
        end
        bcnt <= bcnt - BW'(1);
      end
      ST_WALK: begin
        if (!alu_borrow && cnt_inc < {1'b0, n}) begin
          rem <= alu_y[SW-1:0];
          cnt <= cnt_inc[NW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]   <= id_slot(cfg, k3);
      m_tdata[23:8]  <= fin ? 16'(dur) : 16'(rem);
      m_tdata[39:24] <= 16'(dur);
      m_tuser        <= fin;
    end
  end

endmodule

@@ hdl/keyframe_clip_frame_resolver_core.sv @@
// Keyframe clip frame resolver: top level with register file, sequencer and shared adder.
// Each beat on the slave side carries an elapsed tick count; the block answers with one
// beat naming the keyframe on show, the ticks spent in it, its length and, in tuser, a
// flag set when a once-mode clip has reached its end. All work runs through one shared
// adder/subtractor: a sum over the n frames in use, one compare, TICK_BITS (at most 32)
// restoring-modulo steps, then up to n steps of the frame walk; a once-mode clip past
// its end skips the modulo and the walk. s_tready is high only between items; a finished
// result waits in the output register, so the next item can start while it is unread.
// Registers sit at byte addresses 8*i on the APB port; they must be written only while
// the block is idle, which the user must ensure: the block itself does not enforce it.
module keyframe_clip_frame_resolver_core #(
  parameter int MAX_FRAMES    = 8,
  parameter int DURATION_BITS = 16,
  parameter int TICK_BITS     = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kcfr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kcfr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kcfr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [31:0] elapsed_ticks
  input  logic [kcfr_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] frame_id, [23:8] frame_elapsed, [39:24] frame_length
  output logic [kcfr_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] finished
  output logic                             m_tuser
);
  import kcfr_pkg::*;

  localparam int TW = (TICK_BITS < IN_TDATA_W) ? TICK_BITS : IN_TDATA_W;
  localparam int SW = DURATION_BITS + $clog2(MAX_FRAMES + 1);
  localparam int AW = ((SW > TW) ? SW : TW) + 1;

  cfg_t          cfg;
  alu_op_t       alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_y;
  logic          alu_borrow;

  kcfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcfr_alu #(
    .W (AW)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  kcfr_seq #(
    .MAX_FRAMES    (MAX_FRAMES),
    .DURATION_BITS (DURATION_BITS),
    .TW            (TW),
    .SW            (SW),
    .AW            (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .alu_op     (alu_op),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_y      (alu_y),
    .alu_borrow (alu_borrow)
  );

endmodule
